// File: hdl/fvs_pkg.sv
`timescale 1ns / 1ps
package fvs_pkg;
    localparam int MAX_LEN_DEF    = 64;
    localparam int ELEM_WIDTH_DEF = 24;
    localparam int IN_WIDTH       = 24;
    localparam int VALUE_WIDTH    = 29;
    localparam int STATUS_WIDTH   = 2;
    localparam int ACC_WIDTH      = 64;
    localparam int ROOT_WIDTH     = 32;
    localparam int FRAC_BITS      = 16;

    localparam logic [STATUS_WIDTH-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] ST_ZERO     = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] ST_OVERFLOW = 2'd2;

    localparam logic [VALUE_WIDTH-1:0] DIST_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic [ACC_WIDTH-1:0]   COS_ONE  = 64'd65536;

    // one finished vector set, handed from front to back
    typedef struct packed {
        logic                 mode;
        logic                 overflow;
        logic [ACC_WIDTH-1:0] diff_sq;
        logic [ACC_WIDTH-1:0] dot;
        logic [ACC_WIDTH-1:0] norm_a;
        logic [ACC_WIDTH-1:0] norm_b;
    } job_t;

    typedef enum logic [3:0] {
        BK_IDLE, BK_SQRT_D, BK_SQRT_A, BK_SQRT_B, BK_MUL,
        BK_DIV_INT, BK_DIV_FRAC, BK_OUT
    } bk_state_t;
endpackage

// File: hdl/fvs_front.sv
`timescale 1ns / 1ps
module fvs_front #(
    parameter int MAX_LEN    = fvs_pkg::MAX_LEN_DEF,
    parameter int ELEM_WIDTH = fvs_pkg::ELEM_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [fvs_pkg::IN_WIDTH-1:0]  elem_a,
    input  logic [fvs_pkg::IN_WIDTH-1:0]  elem_b,
    input  logic                          last,
    input  logic                          mode,
    output logic                          job_valid,
    input  logic                          job_ready,
    output fvs_pkg::job_t                 job
);
    localparam int CW = $clog2(MAX_LEN + 2);
    localparam int AW = fvs_pkg::ACC_WIDTH;

    // stage 1: register products; stage 2: accumulate
    logic               p_valid_reg;
    logic               p_last_reg;
    logic               p_take_reg;
    logic [AW-1:0]      p_dd_reg, p_ab_reg, p_aa_reg, p_bb_reg;
    logic [AW-1:0]      sd_reg, sab_reg, saa_reg, sbb_reg;
    logic [CW-1:0]      cnt_reg;
    logic               ovf_reg;
    logic               job_valid_reg;
    fvs_pkg::job_t      job_reg;

    logic signed [ELEM_WIDTH:0]   a_s, b_s, d_s;
    logic signed [2*ELEM_WIDTH+1:0] dd, ab, aa, bb;
    logic                 take;
    logic                 stall;
    logic [AW-1:0]        sd_n, sab_n, saa_n, sbb_n;

    // a closing item waits in stage 1 while the hand-off register is still full
    assign stall = p_valid_reg && p_last_reg && job_valid_reg && !job_ready;
    assign in_ready = !stall;
    assign job_valid = job_valid_reg;
    assign job = job_reg;

    always_comb begin
        a_s  = {elem_a[ELEM_WIDTH-1], elem_a[ELEM_WIDTH-1:0]};
        b_s  = {elem_b[ELEM_WIDTH-1], elem_b[ELEM_WIDTH-1:0]};
        d_s  = a_s - b_s;
        dd   = d_s * d_s;
        ab   = a_s * b_s;
        aa   = a_s * a_s;
        bb   = b_s * b_s;
        take = (cnt_reg < CW'(MAX_LEN));
        sd_n  = sd_reg  + (p_take_reg ? p_dd_reg : '0);
        sab_n = sab_reg + (p_take_reg ? p_ab_reg : '0);
        saa_n = saa_reg + (p_take_reg ? p_aa_reg : '0);
        sbb_n = sbb_reg + (p_take_reg ? p_bb_reg : '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg   <= 1'b0;
            p_last_reg    <= 1'b0;
            p_take_reg    <= 1'b0;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            job_valid_reg <= 1'b0;
            sd_reg <= '0; sab_reg <= '0; saa_reg <= '0; sbb_reg <= '0;
        end else begin
            if (p_valid_reg && p_last_reg && !stall)
                job_valid_reg <= 1'b1;
            else if (job_ready)
                job_valid_reg <= 1'b0;
            if (!stall)
                p_valid_reg <= in_valid && in_ready;
            // closing a set clears overflow; the next set's first item always fits
            ovf_reg <= ((p_valid_reg && p_last_reg && !stall) ? 1'b0 : ovf_reg)
                       | (in_valid && in_ready && !take);
            if (in_valid && in_ready) begin
                p_last_reg <= last;
                p_take_reg <= take;
                p_dd_reg   <= AW'(dd);
                p_ab_reg   <= AW'(ab);
                p_aa_reg   <= AW'(aa);
                p_bb_reg   <= AW'(bb);
                if (last) begin
                    cnt_reg <= '0;
                end else if (take) begin
                    cnt_reg <= cnt_reg + CW'(1);
                end
            end
            if (p_valid_reg && !stall) begin
                if (p_last_reg) begin
                    job_reg.mode     <= mode;
                    job_reg.overflow <= ovf_reg;
                    job_reg.diff_sq  <= sd_n;
                    job_reg.dot      <= sab_n;
                    job_reg.norm_a   <= saa_n;
                    job_reg.norm_b   <= sbb_n;
                    sd_reg <= '0; sab_reg <= '0; saa_reg <= '0; sbb_reg <= '0;
                end else begin
                    sd_reg <= sd_n; sab_reg <= sab_n; saa_reg <= saa_n; sbb_reg <= sbb_n;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_job_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        job_valid_reg && !job_ready |=> job_valid_reg && $stable(job_reg))
        else $error("job changed while waiting");
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(MAX_LEN))
        else $error("count out of range");
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        p_valid_reg && !in_ready |=> p_valid_reg && p_last_reg)
        else $error("closing item dropped while stalled");
`endif
endmodule

// File: hdl/fvs_back.sv
`timescale 1ns / 1ps
module fvs_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              job_valid,
    output logic                              job_ready,
    input  fvs_pkg::job_t                     job,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [fvs_pkg::VALUE_WIDTH-1:0]   out_value,
    output logic [fvs_pkg::STATUS_WIDTH-1:0]  out_status
);
    localparam int AW = fvs_pkg::ACC_WIDTH;
    localparam int RW = fvs_pkg::ROOT_WIDTH;
    localparam int VW = fvs_pkg::VALUE_WIDTH;
    localparam logic [AW-1:0] DIST_MAX_W = AW'(fvs_pkg::DIST_MAX);

    fvs_pkg::bk_state_t state_reg, state_next;
    fvs_pkg::job_t      job_reg, job_next;
    logic [AW-1:0]      x_reg, x_next, r_reg, r_next, bit_reg, bit_next;
    logic [RW-1:0]      sa_reg, sa_next;
    logic [AW-1:0]      den_reg, den_next, rem_reg, rem_next, q_reg, q_next;
    logic [5:0]         n_reg, n_next;
    logic [VW-1:0]      val_reg, val_next;
    logic [1:0]         st_reg, st_next;
    logic               neg;
    logic [AW-1:0]      mag;

    assign out_valid  = (state_reg == fvs_pkg::BK_OUT);
    assign out_value  = val_reg;
    assign out_status = st_reg;
    assign job_ready  = (state_reg == fvs_pkg::BK_IDLE);
    assign neg = job_reg.dot[AW-1];
    assign mag = neg ? (~job_reg.dot + AW'(1)) : job_reg.dot;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fvs_pkg::BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
        job_reg <= job_next; x_reg <= x_next; r_reg <= r_next; bit_reg <= bit_next;
        sa_reg <= sa_next; den_reg <= den_next; rem_reg <= rem_next; q_reg <= q_next;
        n_reg <= n_next; val_reg <= val_next; st_reg <= st_next;
    end

    // back-end sequencer: one root digit per cycle, 32 steps per root; cosine mode then multiplies and divides
    always_comb begin
        state_next = state_reg;
        job_next = job_reg; x_next = x_reg; r_next = r_reg; bit_next = bit_reg;
        sa_next = sa_reg; den_next = den_reg; rem_next = rem_reg; q_next = q_reg;
        n_next = n_reg; val_next = val_reg; st_next = st_reg;
        case (state_reg)
            fvs_pkg::BK_IDLE: begin
                if (job_valid) begin
                    job_next = job;
                    r_next = '0;
                    bit_next = AW'(1) << (AW - 2);
                    val_next = '0;
                    st_next = fvs_pkg::ST_OK;
                    if (job.overflow) begin
                        st_next = fvs_pkg::ST_OVERFLOW;
                        state_next = fvs_pkg::BK_OUT;
                    end else if (!job.mode) begin
                        x_next = job.diff_sq;
                        state_next = fvs_pkg::BK_SQRT_D;
                    end else if (job.norm_a == '0 || job.norm_b == '0) begin
                        st_next = fvs_pkg::ST_ZERO;
                        state_next = fvs_pkg::BK_OUT;
                    end else begin
                        x_next = job.norm_a;
                        state_next = fvs_pkg::BK_SQRT_A;
                    end
                end
            end
            fvs_pkg::BK_SQRT_D, fvs_pkg::BK_SQRT_A, fvs_pkg::BK_SQRT_B: begin
                if (x_reg >= r_reg + bit_reg) begin
                    x_next = x_reg - (r_reg + bit_reg);
                    r_next = (r_reg >> 1) + bit_reg;
                end else begin
                    r_next = r_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg[0]) begin
                    if (state_reg == fvs_pkg::BK_SQRT_D) begin
                        val_next = (r_next > DIST_MAX_W) ? fvs_pkg::DIST_MAX
                                                         : VW'(r_next);
                        state_next = fvs_pkg::BK_OUT;
                    end else if (state_reg == fvs_pkg::BK_SQRT_A) begin
                        sa_next = RW'(r_next);
                        x_next = job_reg.norm_b;
                        r_next = '0;
                        bit_next = AW'(1) << (AW - 2);
                        state_next = fvs_pkg::BK_SQRT_B;
                    end else begin
                        state_next = fvs_pkg::BK_MUL;
                    end
                end
            end
            fvs_pkg::BK_MUL: begin
                // both roots fit in 32 bits, full 64-bit product
                den_next = {{(AW-RW){1'b0}}, sa_reg} * {{(AW-RW){1'b0}}, r_reg[RW-1:0]};
                rem_next = mag;
                q_next = '0;
                n_next = '0;
                state_next = fvs_pkg::BK_DIV_INT;
            end
            fvs_pkg::BK_DIV_INT: begin
                // integer part: at most one subtract matters (>=2 saturates)
                if (rem_reg >= den_reg) begin
                    rem_next = rem_reg - den_reg;
                    q_next = q_reg + AW'(1);
                    if (q_reg != '0) begin
                        q_next = fvs_pkg::COS_ONE;
                        n_next = 6'(fvs_pkg::FRAC_BITS);
                        state_next = fvs_pkg::BK_DIV_FRAC;
                    end
                end else begin
                    state_next = fvs_pkg::BK_DIV_FRAC;
                end
            end
            fvs_pkg::BK_DIV_FRAC: begin
                if (n_reg == 6'(fvs_pkg::FRAC_BITS)) begin
                    if (q_reg > fvs_pkg::COS_ONE) q_next = fvs_pkg::COS_ONE;
                    else q_next = q_reg;
                    val_next = neg ? VW'(~(q_next) + AW'(1)) : VW'(q_next);
                    state_next = fvs_pkg::BK_OUT;
                end else begin
                    n_next = n_reg + 6'd1;
                    if (rem_reg >= den_reg - rem_reg) begin
                        rem_next = rem_reg - (den_reg - rem_reg);
                        q_next = {q_reg[AW-2:0], 1'b1};
                    end else begin
                        rem_next = rem_reg + rem_reg;
                        q_next = {q_reg[AW-2:0], 1'b0};
                    end
                end
            end
            fvs_pkg::BK_OUT: begin
                if (out_ready) state_next = fvs_pkg::BK_IDLE;
            end
            default: state_next = fvs_pkg::BK_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_status))
        else $error("result changed while stalled");
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && st_reg != fvs_pkg::ST_OK |-> val_reg == '0)
        else $error("error result with nonzero value");
    a_take_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        job_ready |-> !out_valid)
        else $error("ready while result pending");
`endif
endmodule

// File: hdl/feature_vector_similarity_core.sv
`timescale 1ns / 1ps
// Feature vector similarity core. Element pairs (signed Q16.8) stream in one per cycle and
// are accumulated through a two-stage multiply/add front end; the pair with tlast closes the
// vectors. The finished sums pass through a one-entry hand-off register to the back end, which
// computes the result with a digit-serial square root and a bit-serial divider: one root in
// euclidean mode, two roots and a division in cosine mode. Meanwhile the front end keeps
// accepting the next vector; only its last pair waits (s_tready low) while the hand-off register
// is still full. m_tdata bits [28:0] carry the value, m_tuser the status (0 ok, 1 zero norm,
// 2 more than MAX_LEN pairs). cfg_wdata selects the metric: 0 euclidean, 1 cosine (reset),
// sampled when the last pair is accumulated.
module feature_vector_similarity_core #(
    parameter int MAX_LEN    = fvs_pkg::MAX_LEN_DEF,
    parameter int ELEM_WIDTH = fvs_pkg::ELEM_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // elem_a [23:0], elem_b [47:24]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // value [28:0], zero fill
    output logic [1:0]  m_tuser,   // status [1:0]
    input  logic        cfg_we,
    input  logic        cfg_wdata
);
    logic          mode_reg;
    logic          job_valid, job_ready;
    fvs_pkg::job_t job;
    logic [fvs_pkg::VALUE_WIDTH-1:0] value;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b1;
        end else if (cfg_we) begin
            mode_reg <= cfg_wdata;
        end
    end

    fvs_front #(.MAX_LEN(MAX_LEN), .ELEM_WIDTH(ELEM_WIDTH)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .elem_a(s_tdata[23:0]), .elem_b(s_tdata[47:24]), .last(s_tlast),
        .mode(mode_reg),
        .job_valid(job_valid), .job_ready(job_ready), .job(job)
    );

    fvs_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .job_valid(job_valid), .job_ready(job_ready), .job(job),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_value(value), .out_status(m_tuser)
    );

    assign m_tdata = {3'b000, value};
endmodule
